FILE: rtl/build_artifact_name_filter_assert.svh
// Assertion macros shared by the name filter modules.
`ifndef BUILD_ARTIFACT_NAME_FILTER_ASSERT_SVH
`define BUILD_ARTIFACT_NAME_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ABNF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABNF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/abnf_pkg.sv
// Package: pattern tables, flag types and helpers for the name filter.
`default_nettype none

package abnf_pkg;

    // Default sizes.
    localparam int TAIL_LEN_DEF = 6;
    localparam int POS_BITS_DEF = 5;

    // Suffix table.
    localparam int NUM_SFX = 7;
    localparam int SFX_MAX = 6;
    typedef logic [8*SFX_MAX-1:0] sfx_txt_t;
    localparam sfx_txt_t SFX_TXT [NUM_SFX] =
        '{".o", ".obj", ".exe", ".pdb", ".dll", ".so", ".dylib"};
    localparam int unsigned SFX_LEN [NUM_SFX] = '{2, 4, 4, 4, 4, 3, 6};

    // Directory prefix table. The third entry is given as byte codes, first
    // character in the top byte.
    localparam int NUM_DIR = 3;
    localparam int DIR_MAX = 11;
    typedef logic [8*DIR_MAX-1:0] dir_txt_t;
    localparam dir_txt_t DIR_TXT [NUM_DIR] =
        '{"build/", ".vs/", 88'h434D616B6546696C65732F};
    localparam int unsigned DIR_LEN [NUM_DIR] = '{6, 4, 11};

    // Exact name table, given as byte codes with the first character in the
    // top byte of each used part.
    localparam int NUM_WHOLE = 3;
    localparam int WHOLE_MAX = 21;
    typedef logic [8*WHOLE_MAX-1:0] whole_txt_t;
    localparam whole_txt_t WHOLE_TXT [NUM_WHOLE] = '{
        168'h636F6D70696C655F636F6D6D616E64732E6A736F6E,
        168'h434D616B6543616368652E747874,
        168'h2E44535F53746F7265
    };
    localparam int unsigned WHOLE_LEN [NUM_WHOLE] = '{21, 14, 9};

    // Per-name match flags.
    typedef struct packed {
        logic [NUM_DIR-1:0]   prefix_alive;
        logic [NUM_DIR-1:0]   prefix_hit;
        logic [NUM_WHOLE-1:0] exact_alive;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{
        prefix_alive: {NUM_DIR{1'b1}},
        prefix_hit:   {NUM_DIR{1'b0}},
        exact_alive:  {NUM_WHOLE{1'b1}}
    };

    // Character k of a suffix; the first character sits in the top byte.
    function automatic logic [7:0] sfx_char(input int unsigned idx, input int unsigned k);
        logic [7:0] ch;
        ch = 8'h00;
        if (k < SFX_LEN[idx])
        begin
            ch = SFX_TXT[idx][8*(SFX_LEN[idx]-1-k) +: 8];
        end
        return ch;
    endfunction

    // Character k of a directory prefix, zero past its end.
    function automatic logic [7:0] dir_char(input int unsigned idx, input int unsigned k);
        logic [7:0] ch;
        ch = 8'h00;
        if (k < DIR_LEN[idx])
        begin
            ch = DIR_TXT[idx][8*(DIR_LEN[idx]-1-k) +: 8];
        end
        return ch;
    endfunction

    // Character k of an exact name, zero past its end.
    function automatic logic [7:0] whole_char(input int unsigned idx, input int unsigned k);
        logic [7:0] ch;
        ch = 8'h00;
        if (k < WHOLE_LEN[idx])
        begin
            ch = WHOLE_TXT[idx][8*(WHOLE_LEN[idx]-1-k) +: 8];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/abnf_match.sv
// Combinational matcher: compares one byte against all patterns.
`default_nettype none

module abnf_match #(
    parameter int TailLen = abnf_pkg::TAIL_LEN_DEF,
    parameter int PosBits = abnf_pkg::POS_BITS_DEF
) (
    input  abnf_pkg::flags_t            flags,
    input  logic [PosBits-1:0]          pos,
    input  logic [7:0]                  name_byte,
    input  logic [TailLen-1:0][7:0]     window,
    output abnf_pkg::flags_t            flags_next,
    output logic                        hit
);

    logic        sfx_hit;
    logic        exact_hit;
    logic        one_sfx;
    int unsigned p;

    // Update prefix and exact flags, test suffixes on the shifted window.
    always_comb
    begin
        flags_next = flags;
        sfx_hit    = 1'b0;
        exact_hit  = 1'b0;
        one_sfx    = 1'b0;
        p          = 32'(pos);

        for (int i = 0; i < abnf_pkg::NUM_DIR; i++)
        begin
            if (flags.prefix_alive[i])
            begin
                if (p < abnf_pkg::DIR_LEN[i] && name_byte == abnf_pkg::dir_char(i, p))
                begin
                    if (p == abnf_pkg::DIR_LEN[i] - 1)
                    begin
                        flags_next.prefix_hit[i] = 1'b1;
                    end
                end
                else
                begin
                    flags_next.prefix_alive[i] = 1'b0;
                end
            end
        end

        for (int i = 0; i < abnf_pkg::NUM_WHOLE; i++)
        begin
            if (flags.exact_alive[i])
            begin
                if (!(p < abnf_pkg::WHOLE_LEN[i] &&
                      name_byte == abnf_pkg::whole_char(i, p)))
                begin
                    flags_next.exact_alive[i] = 1'b0;
                end
            end
            if (flags_next.exact_alive[i] && p == abnf_pkg::WHOLE_LEN[i] - 1)
            begin
                exact_hit = 1'b1;
            end
        end

        // The newest byte sits at the top index of the window.
        for (int i = 0; i < abnf_pkg::NUM_SFX; i++)
        begin
            one_sfx = 1'b1;
            for (int k = 0; k < int'(abnf_pkg::SFX_LEN[i]); k++)
            begin
                if (window[TailLen - int'(abnf_pkg::SFX_LEN[i]) + k] !=
                    abnf_pkg::sfx_char(i, k))
                begin
                    one_sfx = 1'b0;
                end
            end
            sfx_hit = sfx_hit | one_sfx;
        end
    end

    assign hit = (|flags_next.prefix_hit) | sfx_hit | exact_hit;

endmodule

`default_nettype wire

FILE: rtl/abnf_track.sv
// Per-name state: tail window, saturating position and match flags.
`default_nettype none

module abnf_track #(
    parameter int TailLen = abnf_pkg::TAIL_LEN_DEF,
    parameter int PosBits = abnf_pkg::POS_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] name_byte,
    input  logic       last,
    output logic       hit
);

`include "build_artifact_name_filter_assert.svh"

    localparam logic [PosBits-1:0] POS_MAX = {PosBits{1'b1}};

    logic [TailLen-1:0][7:0] window_reg;
    logic [TailLen-1:0][7:0] window_next;
    logic [TailLen-1:0][7:0] win_shift;
    logic [PosBits-1:0]      pos_reg;
    logic [PosBits-1:0]      pos_next;
    abnf_pkg::flags_t        flags_reg;
    abnf_pkg::flags_t        flags_next;
    abnf_pkg::flags_t        flags_upd;

    // Window with the current byte shifted in at the top.
    always_comb
    begin
        win_shift[TailLen-2:0] = window_reg[TailLen-1:1];
        win_shift[TailLen-1]   = name_byte;
    end

    abnf_match #(
        .TailLen (TailLen),
        .PosBits (PosBits)
    ) u_match (
        .flags      (flags_reg),
        .pos        (pos_reg),
        .name_byte  (name_byte),
        .window     (win_shift),
        .flags_next (flags_upd),
        .hit        (hit)
    );

    // Next state: on a step, clear at the end of a name, otherwise advance.
    always_comb
    begin
        window_next = window_reg;
        pos_next    = pos_reg;
        flags_next  = flags_reg;
        if (step)
        begin
            if (last)
            begin
                window_next = '0;
                pos_next    = '0;
                flags_next  = abnf_pkg::FLAGS_RESET;
            end
            else
            begin
                window_next = win_shift;
                flags_next  = flags_upd;
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            flags_reg  <= abnf_pkg::FLAGS_RESET;
        end
        else
        begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
            flags_reg  <= flags_next;
        end
    end

    `ABNF_ASSERT_NEXT(a_clear_on_last, step && last,
        pos_reg == '0 && flags_reg == abnf_pkg::FLAGS_RESET,
        "name state not cleared after final word")
    `ABNF_ASSERT_NEXT(a_pos_count, step && !last && pos_reg != POS_MAX,
        pos_reg == $past(pos_reg) + 1'b1,
        "position did not advance")

endmodule

`default_nettype wire

FILE: rtl/build_artifact_name_filter.sv
// Top level of the file-name ignore filter.
//
//  Channel | Direction | Handshake          | Fields
//  --------+-----------+--------------------+------------------------
//  in      | input     | in_valid/in_stall  | name_byte[7:0], last
//  out     | output    | out_valid/out_stall| ignored
//
// One word is taken per cycle while in_stall is low; the final word of a name lands
// in the input register when it is taken, and the result register loads when that
// word leaves the input register, which a stalled output can hold off.
// Reset (rst_n, asynchronous, active low) clears the window, position and
// match flags and empties both registers.
// Only a final word waits on a stalled output; other words pass through the
// matcher even while a result is held, so in_stall rises only when a final
// word meets a full, stalled result register.
`default_nettype none

module build_artifact_name_filter #(
    parameter int TailLen = abnf_pkg::TAIL_LEN_DEF,
    parameter int PosBits = abnf_pkg::POS_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] name_byte,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       ignored
);

`include "build_artifact_name_filter_assert.svh"

    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       ignored_reg;
    logic       advance;
    logic       in_take;
    logic       hit;

    // A held word moves on unless it is final and the result slot is blocked.
    assign advance  = in_full_reg && (!in_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign in_full_next   = in_take || (in_full_reg && !advance);
    assign out_valid_next = (advance && in_last_reg) || (out_valid_reg && out_stall);

    abnf_track #(
        .TailLen (TailLen),
        .PosBits (PosBits)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .name_byte (in_byte_reg),
        .last      (in_last_reg),
        .hit       (hit)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= name_byte;
            in_last_reg <= last;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            ignored_reg <= hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign ignored   = ignored_reg;

    `ABNF_ASSERT_NOW(a_final_waits, in_full_reg && in_last_reg && out_valid_reg && out_stall,
        in_stall, "final word passed a blocked result register")
    `ABNF_ASSERT_NEXT(a_result_loaded, advance && in_last_reg,
        out_valid_reg && ignored_reg == $past(hit), "result not captured")
    `ABNF_ASSERT_NEXT(a_input_held, in_full_reg && !advance,
        in_full_reg && in_byte_reg == $past(in_byte_reg) && in_last_reg == $past(in_last_reg),
        "held input word changed")

endmodule

`default_nettype wire

FILE: sim/tb_build_artifact_name_filter.sv
// Self-checking testbench for the file-name ignore filter.
`timescale 1ns / 100ps

module tb_build_artifact_name_filter;

    localparam int WINDOW = 6;
    localparam logic [4:0] POS_TOP = 5'd31;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_LEN = 300;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] name_byte;
    logic last;
    logic out_valid;
    logic out_stall;
    logic ignored;

    // Ignore list, kept apart from the design's own tables.
    string suffix_txt [7] = '{".o", ".obj", ".exe", ".pdb", ".dll", ".so", ".dylib"};
    string dir_txt [3];
    string whole_txt [3];
    string alphabet = "./_abcdeijlmnopsuvxyCMFDSt";

    // Filter state as the testbench sees it.
    logic [7:0] tail_bytes [WINDOW];
    logic [4:0] name_pos;
    logic [2:0] dir_live;
    logic [2:0] dir_seen;
    logic [2:0] whole_live;

    bit ignore_due [$];
    logic [7:0] name_buf [$];
    bit due_flag;
    int mismatches = 0;
    int words_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    build_artifact_name_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .name_byte (name_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ignored   (ignored)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] char_at(input string s, input int k);
        return s[k];
    endfunction

    // Turn n byte codes, first character in the top used byte, into text.
    function automatic string text_of(input logic [167:0] v, input int n);
        string s;
        s = "";
        for (int k = n - 1; k >= 0; k--)
        begin
            s = {s, " "};
            s.putc(s.len() - 1, v[8*k +: 8]);
        end
        return s;
    endfunction

    // Fill the prefix and exact name lists.
    function automatic void load_lists();
        dir_txt[0] = "build/";
        dir_txt[1] = ".vs/";
        dir_txt[2] = text_of(168'h434D616B6546696C65732F, 11);
        whole_txt[0] = text_of(168'h636F6D70696C655F636F6D6D616E64732E6A736F6E, 21);
        whole_txt[1] = text_of(168'h434D616B6543616368652E747874, 14);
        whole_txt[2] = text_of(168'h2E44535F53746F7265, 9);
    endfunction

    // Clear the per-name state, as happens after every final word.
    function automatic void clear_name_state();
        for (int k = 0; k < WINDOW; k++)
        begin
            tail_bytes[k] = 8'h00;
        end
        name_pos = 5'd0;
        dir_live = 3'b111;
        dir_seen = 3'b000;
        whole_live = 3'b111;
    endfunction

    // Advance the filter by one word; returns 1 when the word ends a name.
    function automatic bit filter_word(input logic [7:0] b, input bit fin, output bit hit);
        int n;
        bit ok;
        hit = 1'b0;
        // Prefixes and exact names are matched against the position in the name.
        for (int i = 0; i < 3; i++)
        begin
            n = dir_txt[i].len();
            if (dir_live[i])
            begin
                if (name_pos < n && b == char_at(dir_txt[i], name_pos))
                begin
                    if (name_pos == n - 1)
                    begin
                        dir_seen[i] = 1'b1;
                    end
                end
                else
                begin
                    dir_live[i] = 1'b0;
                end
            end
            n = whole_txt[i].len();
            if (whole_live[i] && !(name_pos < n && b == char_at(whole_txt[i], name_pos)))
            begin
                whole_live[i] = 1'b0;
            end
        end
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            tail_bytes[k] = tail_bytes[k + 1];
        end
        tail_bytes[WINDOW - 1] = b;
        if (!fin)
        begin
            if (name_pos != POS_TOP)
            begin
                name_pos = name_pos + 5'd1;
            end
            return 1'b0;
        end
        hit = |dir_seen;
        // Suffixes are matched against the newest bytes of the window.
        for (int i = 0; i < 7; i++)
        begin
            n = suffix_txt[i].len();
            ok = 1'b1;
            for (int k = 0; k < n; k++)
            begin
                if (tail_bytes[WINDOW - n + k] != char_at(suffix_txt[i], k))
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                hit = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (whole_live[i] && name_pos == whole_txt[i].len() - 1)
            begin
                hit = 1'b1;
            end
        end
        clear_name_state();
        return 1'b1;
    endfunction

    // Offer one word and wait for it to be taken, then predict its outcome.
    task automatic send_word(input logic [7:0] b, input bit fin);
        bit hit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        name_byte <= b;
        last <= fin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (filter_word(b, fin, hit))
        begin
            ignore_due.push_back(hit);
        end
    endtask

    task automatic send_name();
        for (int i = 0; i < name_buf.size(); i++)
        begin
            send_word(name_buf[i], i == name_buf.size() - 1);
        end
    endtask

    task automatic append_text(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            name_buf.push_back(char_at(s, k));
        end
    endtask

    task automatic send_text(input string s);
        name_buf.delete();
        append_text(s);
        send_name();
    endtask

    // Characters lean towards those in the list so that near misses are common.
    function automatic logic [7:0] pick_char();
        if ($urandom_range(1))
        begin
            return char_at(alphabet, $urandom_range(alphabet.len() - 1));
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // Mostly short stems, now and then long enough to saturate the position.
    function automatic int stem_len();
        if ($urandom_range(19) == 0)
        begin
            return $urandom_range(25, 40);
        end
        return $urandom_range(0, 8);
    endfunction

    task automatic append_random(input int n);
        repeat (n)
        begin
            name_buf.push_back(pick_char());
        end
    endtask

    // Build one random name: list entries, damaged entries or plain noise.
    task automatic make_random_name();
        int kind;
        int idx;
        name_buf.delete();
        kind = $urandom_range(99);
        if (kind < 20)
        begin
            append_random(stem_len());
            append_text(suffix_txt[$urandom_range(6)]);
        end
        else if (kind < 35)
        begin
            append_text(dir_txt[$urandom_range(2)]);
            append_random(stem_len());
        end
        else if (kind < 45)
        begin
            append_text(whole_txt[$urandom_range(2)]);
        end
        else if (kind < 75)
        begin
            idx = $urandom_range(12);
            if (idx < 7)
            begin
                append_text(suffix_txt[idx]);
            end
            else if (idx < 10)
            begin
                append_text(dir_txt[idx - 7]);
            end
            else
            begin
                append_text(whole_txt[idx - 10]);
            end
            case ($urandom_range(4))
                0: name_buf[$urandom_range(name_buf.size() - 1)] = pick_char();
                1: void'(name_buf.pop_back());
                2: void'(name_buf.pop_front());
                3: name_buf.push_back(pick_char());
                default: name_buf.push_front(pick_char());
            endcase
        end
        else
        begin
            append_random(stem_len() + 1);
        end
        if (name_buf.size() == 0)
        begin
            name_buf.push_back(pick_char());
        end
    endtask

    // Every list entry, near misses, odd bytes and names past the position limit.
    task automatic test_directed();
        send_idle_pct = 34;
        recv_idle_pct = 55;
        send_text(".o");
        send_text("main.obj");
        send_text("app.exe");
        send_text("x.pdb");
        send_text("core.dll");
        send_text(".so");
        send_text("lib.dylib");
        send_text("build/");
        send_text("build/x.c");
        send_text(".vs/cfg");
        send_text({dir_txt[2], "a"});
        send_text(whole_txt[0]);
        send_text(whole_txt[1]);
        send_text(whole_txt[2]);
        // An exact name missing its final character.
        name_buf.delete();
        append_text(whole_txt[0]);
        void'(name_buf.pop_back());
        send_name();
        send_text({whole_txt[1], "x"});
        send_text("xbuild/");
        send_text("a.dylibs");
        send_text(".");
        // Zero bytes match nothing but do not spoil a prefix already found.
        name_buf = '{8'h00};
        send_name();
        name_buf.delete();
        append_text("build/");
        name_buf.push_back(8'h00);
        append_text("q");
        send_name();
        name_buf.delete();
        append_text(".o");
        name_buf.push_back(8'h00);
        send_name();
        // All-ones and low bytes.
        name_buf = '{8'hFF};
        send_name();
        name_buf = '{8'h01, 8'hFF, 8'h80};
        send_name();
        // Long names: the suffix still counts, prefixes stay decided.
        send_text({"aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa", ".dylib"});
        send_text({dir_txt[2], "zzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzz"});
        send_text({whole_txt[2], "zzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzz"});
    endtask

    task automatic test_random(input int n_words, input int send_pct, input int recv_pct);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            make_random_name();
            send_name();
        end
    endtask

    // Hold the output off for a long stretch while short names keep arriving.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = HOLD_LEN;
        repeat (40)
        begin
            name_buf.delete();
            if ($urandom_range(1))
            begin
                append_text(suffix_txt[$urandom_range(6)]);
            end
            else
            begin
                append_random($urandom_range(1, 3));
            end
            send_name();
        end
    endtask

    // Receiver: a long hold-off when asked, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare every result taken with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (ignore_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual ignored=%0b",
                         $time, ignored);
                mismatches++;
            end
            else
            begin
                due_flag = ignore_due.pop_front();
                if (ignored !== due_flag)
                begin
                    $display("%0t: ignored mismatch, expected %0b, actual %0b",
                             $time, due_flag, ignored);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        name_byte = 8'h00;
        last = 1'b0;
        out_stall = 1'b0;
        load_lists();
        clear_name_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(320, 34, 55);
        test_random(320, 55, 34);
        test_backpressure();
        test_random(320, 0, 0);

        // Drain the remaining results, then allow a few cycles for strays.
        in_valid <= 1'b0;
        while (ignore_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: build_artifact_name_filter.f
+incdir+rtl
rtl/abnf_pkg.sv
rtl/abnf_match.sv
rtl/abnf_track.sv
rtl/build_artifact_name_filter.sv
sim/tb_build_artifact_name_filter.sv
